@@ rtl/core/bpc_pkg.sv @@
package bpc_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_BITS = 16;
	localparam int LEN_BITS = 32;
	localparam int REG_IDX_BITS = 2;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_SHORT    = 2'd1,
		REG_LONG     = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		EVT_NONE   = 2'd0,
		EVT_SHORT  = 2'd1,
		EVT_MEDIUM = 2'd2,
		EVT_LONG   = 2'd3
	} press_evt_t;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_BITS-1:0] SHORT_RESET = 16'd300;
	localparam logic [CFG_BITS-1:0] LONG_RESET = 16'd650;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_delay_ms;
		logic [CFG_BITS-1:0] short_limit_ms;
		logic [CFG_BITS-1:0] long_limit_ms;
	} cfg_t;

	typedef struct packed {
		logic                stable_level;
		press_evt_t          press_event;
		logic [LEN_BITS-1:0] press_length_ms;
	} result_t;

endpackage

@@ rtl/core/bpc_in_if.sv @@
interface bpc_in_if;
	logic                           valid;
	logic                           ready;
	logic                           raw_level;
	logic [bpc_pkg::TIME_BITS-1:0] now_ms;

	modport source (output valid, output raw_level, output now_ms, input ready);
	modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

@@ rtl/core/bpc_out_if.sv @@
interface bpc_out_if;
	logic                          valid;
	logic                          ready;
	logic                          stable_level;
	logic [1:0]                    press_event;
	logic [bpc_pkg::LEN_BITS-1:0] press_length_ms;

	modport source (output valid, output stable_level, output press_event,
		output press_length_ms, input ready);
	modport sink (input valid, input stable_level, input press_event,
		input press_length_ms, output ready);
endinterface

@@ rtl/core/bpc_cfg_regs.sv @@
module bpc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bpc_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_BITS-1:0]     cfg_data,
	output bpc_pkg::cfg_t                      cfg
);
	import bpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_delay_ms <= DEBOUNCE_RESET;
			cfg_q.short_limit_ms <= SHORT_RESET;
			cfg_q.long_limit_ms <= LONG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_delay_ms <= cfg_data;
				REG_SHORT:    cfg_q.short_limit_ms <= cfg_data;
				REG_LONG:     cfg_q.long_limit_ms <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/bpc_core.sv @@
module bpc_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bpc_pkg::cfg_t                   cfg,
	input  logic                            commit,
	input  logic                            raw_level,
	input  logic [bpc_pkg::TIME_BITS-1:0] now_ms,
	output bpc_pkg::result_t                res
);
	import bpc_pkg::*;

	logic                 prev_raw_q;
	logic                 deb_q;
	logic [TIME_BITS-1:0] change_q;
	logic [TIME_BITS-1:0] start_q;
	logic                 held_q;

	logic [TIME_BITS-1:0] change_next;
	logic [TIME_BITS-1:0] elapsed;
	logic                 deb_next;
	logic [TIME_BITS-1:0] dur;
	logic [TIME_BITS-1:0] start_next;
	logic                 held_next;
	press_evt_t           evt;

	always_comb begin
		change_next = (raw_level != prev_raw_q) ? now_ms : change_q;
		elapsed = now_ms - change_next;
		deb_next = (elapsed > TIME_BITS'(cfg.debounce_delay_ms)) ? raw_level : deb_q;
		dur = now_ms - start_q;
		start_next = start_q;
		held_next = held_q;
		evt = EVT_NONE;
		priority if (!deb_next && !held_q) begin
			start_next = now_ms;
			held_next = 1'b1;
		end else if (deb_next && held_q) begin
			held_next = 1'b0;
			priority if (dur < TIME_BITS'(cfg.short_limit_ms)) begin
				evt = EVT_SHORT;
			end else if (dur <= TIME_BITS'(cfg.long_limit_ms)) begin
				evt = EVT_MEDIUM;
			end else begin
				evt = EVT_LONG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= 1'b1;
			deb_q <= 1'b1;
			change_q <= '0;
			start_q <= '0;
			held_q <= 1'b0;
		end else if (commit) begin
			prev_raw_q <= raw_level;
			deb_q <= deb_next;
			change_q <= change_next;
			start_q <= start_next;
			held_q <= held_next;
		end
	end

	always_comb begin
		res.stable_level = deb_next;
		res.press_event = evt;
		res.press_length_ms = (evt == EVT_NONE) ? '0 : LEN_BITS'(dur);
	end

endmodule

@@ rtl/core/button_press_classifier.sv @@
// Debounced active-low button with press-length classes. Each sample request
// carries the raw pin level and a wrapping millisecond timestamp; each one
// yields exactly one result request with the debounced level and, on a
// debounced release, the press class and its length. One sample is taken
// every clock cycle unless a stalled result holds the input back; a sample's
// result passes through the input register and then the result register
// around the single update of debounce and press state. The result register
// decouples the sides, so a stalled result only holds the input back once
// both registers are full. Configuration registers must be written only
// while no sample is in flight; the block itself does not enforce this.
module button_press_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	bpc_in_if.sink                             sample,
	bpc_out_if.source                          result,
	input  logic                               cfg_we,
	input  logic [bpc_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_BITS-1:0]     cfg_data
);
	import bpc_pkg::*;

	cfg_t                 cfg;
	logic                 vld_s1;
	logic                 raw_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 vld_s2;
	result_t              res_s2;
	result_t              res;
	logic                 adv_s2;
	logic                 commit;

	assign adv_s2 = !vld_s2 || result.ready;
	assign commit = vld_s1 && adv_s2;
	assign sample.ready = !vld_s1 || adv_s2;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.commit    (commit),
		.raw_level (raw_s1),
		.now_ms    (now_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				vld_s1 <= sample.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_level;
			now_s1 <= sample.now_ms;
		end
		if (commit) begin
			res_s2 <= res;
		end
	end

	assign result.valid = vld_s2;
	assign result.stable_level = res_s2.stable_level;
	assign result.press_event = res_s2.press_event;
	assign result.press_length_ms = res_s2.press_length_ms;

endmodule

@@ rtl/core/bpc_checker.sv @@
module bpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          stable_level,
	input logic [1:0]                    press_event,
	input logic [bpc_pkg::LEN_BITS-1:0] press_length_ms
);
	import bpc_pkg::*;

	// stalled result keeps its request
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	// stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
		$stable(stable_level) && $stable(press_event) && $stable(press_length_ms))
		else $error("result payload changed while stalled");

	// no press event means no length
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && press_event == EVT_NONE |-> press_length_ms == '0)
		else $error("press length without press event");

	// a press ends only on a released debounced level
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && press_event != EVT_NONE |-> stable_level)
		else $error("press event while button still held");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.stable_level    (result.stable_level),
	.press_event     (result.press_event),
	.press_length_ms (result.press_length_ms)
);

@@ sim/button_press_classifier_tb.sv @@
`timescale 1ns / 100ps

module button_press_classifier_tb;
	import bpc_pkg::*;

	localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int SETTLE_CYCLES = 4;

	class press_scoreboard;
		logic [CFG_BITS-1:0] debounce_ms;
		logic [CFG_BITS-1:0] short_ms;
		logic [CFG_BITS-1:0] long_ms;
		bit last_raw;
		bit level;
		bit held;
		bit [TIME_BITS-1:0] change_stamp;
		bit [TIME_BITS-1:0] press_stamp;
		result_t expected_q[$];
		int errors;

		function void reset_state();
			debounce_ms = DEBOUNCE_RESET;
			short_ms = SHORT_RESET;
			long_ms = LONG_RESET;
			last_raw = 1'b1;
			level = 1'b1;
			held = 1'b0;
			change_stamp = '0;
			press_stamp = '0;
			expected_q.delete();
			errors = 0;
		endfunction

		function void write_register(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			case (idx)
				REG_DEBOUNCE: debounce_ms = data;
				REG_SHORT: short_ms = data;
				REG_LONG: long_ms = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// predict the result of one accepted sample
		function void note_sample(bit raw, bit [TIME_BITS-1:0] now);
			bit [TIME_BITS-1:0] elapsed;
			bit [TIME_BITS-1:0] dur;
			result_t r;
			if (raw != last_raw) begin
				change_stamp = now;
			end
			elapsed = now - change_stamp;
			if (elapsed > debounce_ms) begin
				level = raw;
			end
			last_raw = raw;
			r.stable_level = level;
			r.press_event = EVT_NONE;
			r.press_length_ms = '0;
			if (!level && !held) begin
				press_stamp = now;
				held = 1'b1;
			end else if (level && held) begin
				dur = now - press_stamp;
				if (dur < short_ms) begin
					r.press_event = EVT_SHORT;
				end else if (dur <= long_ms) begin
					r.press_event = EVT_MEDIUM;
				end else begin
					r.press_event = EVT_LONG;
				end
				r.press_length_ms = dur;
				held = 1'b0;
			end
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 40) begin
					$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				end
			end
		endfunction

		function void check_result(logic stable, logic [1:0] evt, logic [LEN_BITS-1:0] len);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 40) begin
					$display("%0t: result with nothing expected: level %0h event %0h length %0h",
						$time, stable, evt, len);
				end
			end else begin
				want = expected_q.pop_front();
				compare_field("stable_level", 32'(want.stable_level), 32'(stable));
				compare_field("press_event", 32'(want.press_event), 32'(evt));
				compare_field("press_length_ms", want.press_length_ms, len);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	bpc_in_if sample_if ();
	bpc_out_if result_if ();

	button_press_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_if),
		.result(result_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	press_scoreboard sb;
	bit no_idle;
	int sent;
	int cycles;
	bit [TIME_BITS-1:0] now_cursor;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// result side: random stalls, check every accepted result
	initial begin
		int stall;
		stall = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
				sb.check_result(result_if.stable_level, result_if.press_event,
					result_if.press_length_ms);
			end
			if (stall > 0) begin
				stall--;
				result_if.ready <= 1'b0;
			end else begin
				stall = ($urandom_range(0, 99) < 20) ? pick_gap() : 0;
				result_if.ready <= (stall == 0);
			end
		end
	end

	task automatic send_sample(input bit raw, input bit [TIME_BITS-1:0] now);
		int gap;
		sample_if.valid <= 1'b1;
		sample_if.raw_level <= raw;
		sample_if.now_ms <= now;
		do @(posedge clk); while (sample_if.ready !== 1'b1);
		sb.note_sample(raw, now);
		sent++;
		gap = pick_gap();
		if (gap > 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_register(idx, data);
		@(posedge clk);
	endtask

	task automatic drain();
		sample_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_BITS-1:0] d, input logic [CFG_BITS-1:0] s,
		input logic [CFG_BITS-1:0] l);
		drain();
		write_reg(REG_DEBOUNCE, d);
		write_reg(REG_UNUSED, CFG_BITS'($urandom_range(0, 65535)));
		write_reg(REG_SHORT, s);
		write_reg(REG_LONG, l);
		cfg_we <= 1'b0;
	endtask

	// press held for exactly dur between the debounced edges
	task automatic press_exact(input bit [TIME_BITS-1:0] t, input bit [TIME_BITS-1:0] dur);
		bit [TIME_BITS-1:0] d1;
		d1 = sb.debounce_ms + 1;
		send_sample(1'b0, t);
		send_sample(1'b0, t + d1);
		send_sample(1'b1, t + dur);
		send_sample(1'b1, t + dur + d1);
		now_cursor = t + dur + d1;
	endtask

	function automatic bit [TIME_BITS-1:0] pick_hold();
		int unsigned s;
		int unsigned l;
		s = 32'(sb.short_ms);
		l = 32'(sb.long_ms);
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, s);
			1: return s + $urandom_range(0, 2) - 1;
			2: return $urandom_range(s, l);
			3: return l + $urandom_range(0, 2) - 1;
			default: return l + $urandom_range(1, 5000);
		endcase
	endfunction

	task automatic bounce(input bit settle_raw);
		int n;
		n = $urandom_range(0, 3);
		repeat (n) begin
			send_sample(settle_raw, now_cursor);
			now_cursor += $urandom_range(0, sb.debounce_ms);
			send_sample(!settle_raw, now_cursor);
			now_cursor += $urandom_range(0, sb.debounce_ms);
		end
	endtask

	// one bouncy press and release with a chosen hold time
	task automatic gesture();
		int unsigned hold_left;
		int unsigned step;
		int extra;
		bounce(1'b0);
		hold_left = pick_hold();
		send_sample(1'b0, now_cursor);
		now_cursor += sb.debounce_ms + 1;
		send_sample(1'b0, now_cursor);
		extra = $urandom_range(0, 3);
		repeat (extra) begin
			step = $urandom_range(0, hold_left);
			now_cursor += step;
			hold_left -= step;
			send_sample(1'b0, now_cursor);
		end
		now_cursor += hold_left;
		bounce(1'b1);
		send_sample(1'b1, now_cursor);
		now_cursor += sb.debounce_ms + 1;
		send_sample(1'b1, now_cursor);
		repeat ($urandom_range(0, 2)) begin
			now_cursor += $urandom_range(0, 2 * sb.debounce_ms + 10);
			send_sample(1'b1, now_cursor);
		end
	endtask

	task automatic noise();
		bit [TIME_BITS-1:0] t;
		if ($urandom_range(0, 1)) begin
			t = $urandom();
		end else begin
			t = now_cursor + $urandom_range(0, 3 * sb.debounce_ms + 3);
		end
		send_sample(1'($urandom_range(0, 1)), t);
		if ($urandom_range(0, 1)) begin
			now_cursor = t;
		end
	endtask

	task automatic random_traffic(input int n);
		int target;
		target = sent + n;
		while (sent < target) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 6)) noise();
			end else begin
				gesture();
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_BITS-1:0] d, input logic [CFG_BITS-1:0] s,
		input logic [CFG_BITS-1:0] l);
		configure(d, s, l);
		if ($urandom_range(0, 3) == 0) begin
			now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		end
		press_exact(now_cursor + 100, TIME_BITS'(s));
		press_exact(now_cursor + 100, l + 1);
		random_traffic(ITEMS_PER_PHASE);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		no_idle = 1'b0;
		sent = 0;
		now_cursor = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= '0;
		sample_if.valid <= 1'b0;
		sample_if.raw_level <= 1'b1;
		sample_if.now_ms <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: class boundaries, delay boundary, wrap, time going back
		send_sample(1'b1, 32'd0);
		send_sample(1'b0, 32'd1000);
		send_sample(1'b0, 32'd1050);
		send_sample(1'b0, 32'd1051);
		send_sample(1'b1, 32'd1299);
		send_sample(1'b1, 32'd1350);
		press_exact(32'd2000, 32'd300);
		press_exact(32'd3000, 32'd650);
		press_exact(32'd4000, 32'd651);
		press_exact(32'hFFFF_FE00, 32'd1000);
		send_sample(1'b0, 32'd500);
		send_sample(1'b0, 32'd400);
		send_sample(1'b1, 32'd300);
		send_sample(1'b1, 32'hFFFF_FFFF);
		now_cursor = 32'd5000;
		random_traffic(ITEMS_PER_PHASE);

		run_phase(16'd0, SHORT_RESET, LONG_RESET);
		run_phase(16'd0, 16'd0, 16'd0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(16'd20, 16'd500, 16'd100);
		run_phase(CFG_BITS'($urandom_range(0, 200)), CFG_BITS'($urandom_range(0, 2000)),
			CFG_BITS'($urandom_range(0, 4000)));
		run_phase(CFG_BITS'($urandom_range(0, 65535)), CFG_BITS'($urandom_range(0, 65535)),
			CFG_BITS'($urandom_range(0, 65535)));

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
